### src/dasm_pkg.sv
package dasm_pkg;

  // Number of pattern bytes, and so of match cells, the block is built for (1 to 32).
  localparam int PATTERN_MAX = 32;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int INDEX_W   = 3;
  localparam int CFG_W     = 64;
  localparam int POS_W     = 32;
  localparam int WORDS     = 4;
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_DELTA          = 3'd0;
  localparam logic [INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [INDEX_W-1:0] REG_PATTERN_WORD0  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_PATTERN_WORD1  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_PATTERN_WORD2  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_PATTERN_WORD3  = 3'd5;

  // Shared controls broadcast to every match cell
  typedef struct packed {
    logic              advance;
    logic              clear;
    logic [BYTE_W-1:0] text_byte;
    logic [BYTE_W-1:0] delta;
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_position;
    logic             text_done;
    logic             none_found;
    logic             text_too_short;
  } result_t;

endpackage

### src/dasm_cell.sv
module dasm_cell
  import dasm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] pattern_byte,
  input  logic              in_use,
  input  logic              prev_bit,
  output logic              bit_next,
  output logic              bit_q
);

  logic [BYTE_W-1:0] diff;
  logic              close;

  assign diff     = (pattern_byte > ctrl.text_byte) ? (pattern_byte - ctrl.text_byte)
                                                    : (ctrl.text_byte - pattern_byte);
  assign close    = in_use && (diff <= ctrl.delta);
  // Extend the prefix held by the left neighbor when this byte is close enough.
  assign bit_next = prev_bit && close;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_q <= 1'b0;
    end else if (ctrl.advance) begin
      bit_q <= ctrl.clear ? 1'b0 : bit_next;
    end
  end

endmodule

### src/dasm_out_buf.sv
module dasm_out_buf
  import dasm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign room = !skid_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

### src/delta_approximate_string_match.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    text_byte, end_of_text
// output    out        out_valid / out_ready  match_found, match_position, text_done,
//                                             none_found, text_too_short
// config    in         cfg_write              cfg_index, cfg_data
//
// One text byte is taken per cycle while the buffer has room; its result is
// registered in the output register, or in the skid entry when that is full.
// All prefix bits update in the transfer cycle; one item per clock unless input stalls.
// A two-entry output buffer (output register plus skid) parts the sides: input
// stalls only when both entries hold results that have not been taken.
// Synchronous reset clears prefix bits, byte count, match flag, buffer valids and
// the registers (delta 0, length 1, pattern 0).
module delta_approximate_string_match
  import dasm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  text_byte,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               match_found,
  output logic [POS_W-1:0]   match_position,
  output logic               text_done,
  output logic               none_found,
  output logic               text_too_short,
  input  logic               cfg_write,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  // Configuration registers
  logic [BYTE_W-1:0]       delta;
  logic [LEN_W-1:0]        pattern_length;
  logic [WORDS*CFG_W-1:0]  pattern_bytes;

  // Per-text state
  logic [POS_W-1:0]        byte_count;
  logic                    any_match_seen;

  logic                    advance;
  logic [LEN_W-1:0]        used_len;
  logic [LEN_W-1:0]        last_cell;
  cell_ctrl_t              ctrl;
  logic [PATTERN_MAX-1:0]  bits_q;
  logic [PATTERN_MAX-1:0]  bits_next;
  logic                    hit;
  result_t                 res;
  result_t                 out_data;
  logic                    room;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta          <= '0;
      pattern_length <= LEN_W'(1);
      pattern_bytes  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELTA:          delta                  <= cfg_data[BYTE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length         <= cfg_data[LEN_W-1:0];
        REG_PATTERN_WORD0:  pattern_bytes[0*CFG_W +: CFG_W] <= cfg_data;
        REG_PATTERN_WORD1:  pattern_bytes[1*CFG_W +: CFG_W] <= cfg_data;
        REG_PATTERN_WORD2:  pattern_bytes[2*CFG_W +: CFG_W] <= cfg_data;
        REG_PATTERN_WORD3:  pattern_bytes[3*CFG_W +: CFG_W] <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamp the length into 1..PATTERN_MAX.
  always_comb begin
    if (pattern_length == '0) begin
      used_len = LEN_W'(1);
    end else if (pattern_length > LEN_MAX) begin
      used_len = LEN_MAX;
    end else begin
      used_len = pattern_length;
    end
  end

  assign last_cell = used_len - LEN_W'(1);

  assign in_ready = room;
  assign advance  = in_valid && in_ready;

  assign ctrl.advance   = advance;
  assign ctrl.clear     = end_of_text;
  assign ctrl.text_byte = text_byte;
  assign ctrl.delta     = delta;

  // Row of match cells: cell i holds "pattern prefix of length i+1 ends here".
  // Cell 0 always starts a fresh prefix; others take the left neighbor's bit.
  genvar i;
  generate
    for (i = 0; i < PATTERN_MAX; i++) begin : g_cell
      logic prev_bit;
      if (i == 0) begin : g_first
        assign prev_bit = 1'b1;
      end else begin : g_rest
        assign prev_bit = bits_q[i-1];
      end
      dasm_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .pattern_byte (pattern_bytes[i*BYTE_W +: BYTE_W]),
        .in_use       (used_len > LEN_W'(i)),
        .prev_bit     (prev_bit),
        .bit_next     (bits_next[i]),
        .bit_q        (bits_q[i])
      );
    end
  endgenerate

  // A full match ends here when the last cell in use lights up.
  assign hit = bits_next[last_cell[IDX_W-1:0]];

  always_comb begin
    res.match_found    = hit;
    res.match_position = hit ? (byte_count - POS_W'(last_cell)) : '0;
    res.text_done      = end_of_text;
    res.none_found     = end_of_text && !(any_match_seen || hit);
    res.text_too_short = end_of_text &&
                         (({1'b0, byte_count} + (POS_W+1)'(1)) < (POS_W+1)'(used_len));
  end

  // Advance the byte index, saturating; clear per-text state at end of text.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      any_match_seen <= 1'b0;
    end else if (advance) begin
      if (end_of_text) begin
        byte_count     <= '0;
        any_match_seen <= 1'b0;
      end else begin
        if (byte_count != '1) begin
          byte_count <= byte_count + POS_W'(1);
        end
        if (hit) begin
          any_match_seen <= 1'b1;
        end
      end
    end
  end

  dasm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign match_found    = out_data.match_found;
  assign match_position = out_data.match_position;
  assign text_done      = out_data.text_done;
  assign none_found     = out_data.none_found;
  assign text_too_short = out_data.text_too_short;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import dasm_pkg::*;

  // Register indexes past the end of the list; the block must ignore them
  localparam logic [INDEX_W-1:0] REG_SPARE0 = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE1 = 3'd7;

  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 250;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  text_byte = '0;
  logic               end_of_text = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               match_found;
  logic [POS_W-1:0]   match_position;
  logic               text_done;
  logic               none_found;
  logic               text_too_short;
  logic               cfg_write = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  delta_approximate_string_match DUT (.*);

  // Matcher state as the block should hold it
  logic [BYTE_W-1:0]  delta_q = '0;
  logic [LEN_W-1:0]   pat_len_q = 6'd1;
  logic [CFG_W-1:0]   pat_word_q [WORDS] = '{default: '0};
  logic [31:0]        prefix_bits_q = '0;
  logic [POS_W-1:0]   byte_index_q = '0;
  logic               any_match_q = 1'b0;

  result_t            expected_results [$];
  int                 errors = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_asked = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop; far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when the test asks for one.
  // The hold is counted here so only this process owns the counter.
  always @(posedge clk) begin : receiver
    int hold_seen;
    int hold_left;
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  function automatic int used_length();
    if (pat_len_q == 0) return 1;
    if (pat_len_q > PATTERN_MAX) return PATTERN_MAX;
    return int'(pat_len_q);
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_at(input int i);
    return pat_word_q[i >> 3][(i & 7) * 8 +: 8];
  endfunction

  // Advance the shift-and state by one text byte and return the result it makes
  function automatic result_t match_step(input logic [BYTE_W-1:0] c, input logic last);
    result_t     r;
    int          m;
    int          i;
    logic [31:0] accept;
    logic [7:0]  p;
    logic [7:0]  d;
    m = used_length();
    accept = '0;
    for (i = 0; i < m; i++) begin
      p = pattern_at(i);
      d = (p > c) ? p - c : c - p;
      if (d <= delta_q) accept[i] = 1'b1;
    end
    prefix_bits_q = ((prefix_bits_q << 1) | 32'd1) & accept;
    r = '0;
    r.match_found = prefix_bits_q[m-1];
    if (r.match_found) begin
      r.match_position = byte_index_q - POS_W'(m - 1);
      any_match_q = 1'b1;
    end
    r.text_done = last;
    if (last) begin
      r.none_found = !any_match_q;
      r.text_too_short = (({1'b0, byte_index_q} + 33'd1) < 33'(m));
      prefix_bits_q = '0;
      byte_index_q = '0;
      any_match_q = 1'b0;
    end else if (byte_index_q != '1) begin
      byte_index_q = byte_index_q + 1'b1;
    end
    return r;
  endfunction

  // Offer one byte, hold it until the transfer, then record what must come out
  task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(match_step(b, last));
  endtask

  // Drop valid and wait until every result is back; registers may change after
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Leaves cfg_write high; the caller drops it after its last write
  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_DELTA:          delta_q = data[BYTE_W-1:0];
      REG_PATTERN_LENGTH: pat_len_q = data[LEN_W-1:0];
      REG_PATTERN_WORD0:  pat_word_q[0] = data;
      REG_PATTERN_WORD1:  pat_word_q[1] = data;
      REG_PATTERN_WORD2:  pat_word_q[2] = data;
      REG_PATTERN_WORD3:  pat_word_q[3] = data;
      default: ;
    endcase
  endtask

  // Write all six registers; junk in the unused high bits must be dropped
  task automatic configure(input logic [7:0] d, input logic [5:0] len,
                           input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] w3);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_DELTA, {junk[63:8], d});
    write_reg(REG_PATTERN_LENGTH, {junk[63:6], len});
    write_reg(REG_PATTERN_WORD0, w0);
    write_reg(REG_PATTERN_WORD1, w1);
    write_reg(REG_PATTERN_WORD2, w2);
    write_reg(REG_PATTERN_WORD3, w3);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // A byte within delta of p
  function automatic logic [7:0] near_byte(input logic [7:0] p);
    int lo;
    int hi;
    lo = (int'(p) > int'(delta_q)) ? int'(p) - int'(delta_q) : 0;
    hi = (int'(p) + int'(delta_q) > 255) ? 255 : int'(p) + int'(delta_q);
    return 8'($urandom_range(hi, lo));
  endfunction

  // A byte just or well outside delta of p, when one exists
  function automatic logic [7:0] far_byte(input logic [7:0] p);
    int up;
    int dn;
    up = int'(p) + int'(delta_q) + 1;
    dn = int'(p) - int'(delta_q) - 1;
    if (up <= 255 && (dn < 0 || $urandom_range(1, 0) == 1)) return 8'($urandom_range(255, up));
    if (dn >= 0) return 8'($urandom_range(dn, 0));
    return 8'($urandom);
  endfunction

  task automatic random_config();
    logic [7:0] d;
    logic [5:0] len;
    case ($urandom_range(4, 0))
      0: d = 8'd0;
      1: d = 8'd255;
      2: d = 8'($urandom_range(8, 0));
      default: d = 8'($urandom);
    endcase
    case ($urandom_range(9, 0))
      0: len = 6'd0;
      1: len = 6'($urandom_range(63, 33));
      2: len = 6'd32;
      3: len = 6'd1;
      default: len = 6'($urandom_range(12, 2));
    endcase
    configure(d, len, rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // Build one text from planted copies of the pattern (clean or with one bad
  // byte) and noise, then send it. Returns the number of bytes sent.
  task automatic send_random_text(output int n);
    logic [7:0] text_q [$];
    int         m;
    int         target;
    int         i;
    int         bad;
    m = used_length();
    if (m > 1 && $urandom_range(9, 0) == 0) target = $urandom_range(m - 1, 1);
    else target = $urandom_range(3 * m + 4, m);
    while (text_q.size() < target) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4: begin
          for (i = 0; i < m; i++) text_q.push_back(near_byte(pattern_at(i)));
        end
        5, 6: begin
          bad = $urandom_range(m - 1, 0);
          for (i = 0; i < m; i++)
            text_q.push_back(i == bad ? far_byte(pattern_at(i)) : near_byte(pattern_at(i)));
        end
        7: text_q.push_back($urandom_range(1, 0) ? 8'hFF : 8'h00);
        default: text_q.push_back(8'($urandom));
      endcase
    end
    while (text_q.size() > target) void'(text_q.pop_back());
    // Now and then leave the text open so it runs on across the next one
    for (i = 0; i < target; i++)
      send_text_byte(text_q[i], (i == target - 1) && ($urandom_range(9, 0) != 0));
    n = target;
  endtask

  // Defaults after reset: delta 0, length 1, pattern all zero bytes
  task automatic test_reset_values();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h00, 1'b1);
    wait_drained();
  endtask

  // Length zero acts as one; lengths past the top act as the top
  task automatic test_length_limits();
    configure(8'd255, 6'd0, rand_word(), rand_word(), rand_word(), rand_word());
    send_text_byte(8'hFF, 1'b1);
    wait_drained();
    configure(8'd0, 6'd40, rand_word(), rand_word(), rand_word(), rand_word());
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  // Pattern 00 FF 03 80 with delta 3: first window sits exactly on the
  // boundary, the second misses by one on its third byte
  task automatic test_delta_edges();
    configure(8'd3, 6'd4, {$urandom, 32'h8003FF00}, rand_word(), rand_word(), rand_word());
    send_text_byte(8'd3, 1'b0);
    send_text_byte(8'd252, 1'b0);
    send_text_byte(8'd0, 1'b0);
    send_text_byte(8'd131, 1'b0);
    send_text_byte(8'd0, 1'b0);
    send_text_byte(8'd255, 1'b0);
    send_text_byte(8'd7, 1'b0);
    send_text_byte(8'd128, 1'b1);
    wait_drained();
  endtask

  // Prefix bits survive a pattern change in the middle of a text
  task automatic test_config_mid_text();
    configure(8'd0, 6'd2, {$urandom, 16'($urandom), 16'h0605}, rand_word(), rand_word(),
              rand_word());
    send_text_byte(8'h05, 1'b0);
    wait_drained();
    write_reg(REG_PATTERN_WORD0, {$urandom, 16'($urandom), 16'h0705});
    cfg_write <= 1'b0;
    send_text_byte(8'h07, 1'b1);
    wait_drained();
  endtask

  // Writes to indexes past the list must leave the registers alone
  task automatic test_ignored_index();
    write_reg(REG_SPARE0, rand_word());
    write_reg(REG_SPARE1, rand_word());
    cfg_write <= 1'b0;
    send_text_byte(8'h05, 1'b0);
    send_text_byte(8'h07, 1'b1);
    wait_drained();
  endtask

  // Hold the output off for a long stretch while bytes keep coming, so the
  // buffer fills and the input stalls
  task automatic test_backpressure();
    int sent;
    int n;
    send_idle_pct = 0;
    stall_pct = 0;
    configure(8'd1, 6'd3, rand_word(), rand_word(), rand_word(), rand_word());
    hold_asked = hold_asked + 1;
    sent = 0;
    while (sent < 40) begin
      send_random_text(n);
      sent += n;
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall);
    int sent;
    int texts;
    int n;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    texts = 0;
    while (sent < ITEMS_PER_PHASE) begin
      // Reconfigure every few texts; in between, texts flow back to back
      if (texts % 4 == 0) begin
        wait_drained();
        random_config();
      end
      send_random_text(n);
      sent += n;
      texts++;
    end
    wait_drained();
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Compare every output transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got match %0b pos %0h done %0b",
                 $time, match_found, match_position, text_done);
      end else begin
        want = expected_results.pop_front();
        check_field("match_found", 32'(want.match_found), 32'(match_found));
        check_field("match_position", want.match_position, match_position);
        check_field("text_done", 32'(want.text_done), 32'(text_done));
        check_field("none_found", 32'(want.none_found), 32'(none_found));
        check_field("text_too_short", 32'(want.text_too_short), 32'(text_too_short));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_length_limits();
    test_delta_edges();
    test_config_mid_text();
    test_ignored_index();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(49, 0);
    test_random_traffic(0, 49);
    test_random_traffic(15, 15);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
